// File: design/accelerometer_tilt_angle_macros.svh
// Assertion helpers used by the checker file
`ifndef ACCELEROMETER_TILT_ANGLE_MACROS_SVH
`define ACCELEROMETER_TILT_ANGLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ATA_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("tilt checker: same-cycle rule violated");

// Next-cycle implication, off while reset is asserted
`define ATA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("tilt checker: next-cycle rule violated");

`endif

// File: design/atr_pkg.sv
`timescale 1ns / 1ps
package atr_pkg;

	localparam int ADC_BITS         = 12;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int REG_W            = 12;
	localparam int TILT_W           = 15;
	localparam int FULL_SCALE_MV    = 3600;
	localparam int QUARTER_CENTIDEG = 9000;

	// Datapath widths
	localparam int MAG_W     = ADC_BITS + 12;
	localparam int DIFF_W    = MAG_W + 1;
	localparam int GPROD_W   = 2 * REG_W;
	localparam int PROD_W    = MAG_W + GPROD_W;
	localparam int NORM_BITS = 30;
	localparam int SHIFT_W   = $clog2(PROD_W - NORM_BITS + 1);
	localparam int POS_W     = $clog2(PROD_W);
	localparam int SUM_BITS  = 2 * NORM_BITS + 1;
	localparam int ROOT_BITS = NORM_BITS + 1;
	localparam int CX_BITS   = ROOT_BITS + 3;
	localparam int ANG_BITS  = 32;
	localparam int MAGN_W    = 14;

	// Arctangent of 2^-i in units of 2^-16 centidegree
	localparam int ATAN_LEN = 12;
	localparam logic [63:0] RAD_UNITS = 64'd375493621;
	localparam logic [ANG_BITS-1:0] ATAN_UNITS [ATAN_LEN] = '{
		32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
		32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
		32'd1466764,   32'd733385,    32'd366693,   32'd183346
	};

	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_BIAS_X = 3'd0,
		REG_BIAS_Y = 3'd1,
		REG_BIAS_Z = 3'd2,
		REG_GAIN_X = 3'd3,
		REG_GAIN_Y = 3'd4,
		REG_GAIN_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] sample_x;
		logic [ADC_BITS-1:0] sample_y;
		logic [ADC_BITS-1:0] sample_z;
	} in_t;

	typedef struct packed {
		logic signed [TILT_W-1:0] tilt_centideg;
		logic                     undefined_flag;
	} out_t;

	// Per-item flags that ride along the pipeline
	typedef struct packed {
		logic all_zero;
		logic xz_zero;
		logic neg_y;
	} side_t;

	function automatic logic [ANG_BITS-1:0] step_angle(input int i);
		logic [63:0] t;
		begin
			t = '0;
			if (i < ATAN_LEN) begin
				t = {32'd0, ATAN_UNITS[i]};
			end else if (i < 40) begin
				t = (RAD_UNITS + (64'd1 << (i - 1))) >> i;
			end
			return t[ANG_BITS-1:0];
		end
	endfunction

endpackage

// File: design/atr_front.sv
`timescale 1ns / 1ps
module atr_front import atr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  in_t                   in_data,
	input  logic [REG_W-1:0]      bias [3],
	input  logic [REG_W-1:0]      gain [3],
	output logic                  valid,
	output logic [SUM_BITS-1:0]   sum,
	output logic [NORM_BITS-1:0]  y_mag,
	output side_t                 side
);

	logic [ADC_BITS-1:0] cnt [3];
	logic signed [DIFF_W-1:0] diff [3];
	logic [REG_W-1:0] gnz [3];

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [MAG_W-1:0]   mag_s1 [3];
	logic [GPROD_W-1:0] gp_s1 [3];
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [PROD_W-1:0]  prod_s2 [3];
	logic [PROD_W-1:0]  prod_s3 [3];
	logic [SHIFT_W-1:0] sh_s3;
	logic [NORM_BITS-1:0] nx_s4, ny_s4, nz_s4;
	logic [2*NORM_BITS-1:0] sqx_s5, sqz_s5;
	logic [NORM_BITS-1:0] ny_s5, ny_s6;
	logic [SUM_BITS-1:0] sum_s6;

	logic [PROD_W-1:0] or_all;
	logic [POS_W-1:0]  msb;
	logic [SHIFT_W-1:0] sh;

	assign cnt[0] = in_data.sample_x;
	assign cnt[1] = in_data.sample_y;
	assign cnt[2] = in_data.sample_z;

	// Convert counts to voltage offset from bias, zero gain read as one
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = $signed({1'b0, MAG_W'(cnt[k]) * MAG_W'(FULL_SCALE_MV)})
				- $signed({1'b0, bias[k], {ADC_BITS{1'b0}}});
			gnz[k]  = (gain[k] == '0) ? REG_W'(1) : gain[k];
		end
	end

	// Find the leading one of the largest magnitude
	always_comb begin
		or_all = prod_s2[0] | prod_s2[1] | prod_s2[2];
		msb = '0;
		for (int p = 0; p < PROD_W; p++) begin
			if (or_all[p]) msb = POS_W'(p);
		end
		sh = (msb >= POS_W'(NORM_BITS - 1)) ? SHIFT_W'(msb - POS_W'(NORM_BITS - 1)) : '0;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Advance payload: magnitudes, cross scaling, normalization, squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= diff[k][DIFF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
			end
			gp_s1[0] <= gnz[1] * gnz[2];
			gp_s1[1] <= gnz[0] * gnz[2];
			gp_s1[2] <= gnz[0] * gnz[1];
			side_s1.all_zero <= (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
			side_s1.xz_zero  <= (diff[0] == '0) && (diff[2] == '0);
			side_s1.neg_y    <= diff[1][DIFF_W-1];

			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= PROD_W'(mag_s1[k]) * PROD_W'(gp_s1[k]);
			end
			side_s2 <= side_s1;

			prod_s3 <= prod_s2;
			sh_s3   <= sh;
			side_s3 <= side_s2;

			nx_s4   <= NORM_BITS'(prod_s3[0] >> sh_s3);
			ny_s4   <= NORM_BITS'(prod_s3[1] >> sh_s3);
			nz_s4   <= NORM_BITS'(prod_s3[2] >> sh_s3);
			side_s4 <= side_s3;

			sqx_s5  <= nx_s4 * nx_s4;
			sqz_s5  <= nz_s4 * nz_s4;
			ny_s5   <= ny_s4;
			side_s5 <= side_s4;

			sum_s6  <= SUM_BITS'(sqx_s5) + SUM_BITS'(sqz_s5);
			ny_s6   <= ny_s5;
			side_s6 <= side_s5;
		end
	end

	assign valid = valid_s6;
	assign sum   = sum_s6;
	assign y_mag = ny_s6;
	assign side  = side_s6;

endmodule

// File: design/atr_sqrt_cell.sv
`timescale 1ns / 1ps
module atr_sqrt_cell import atr_pkg::*; #(
	parameter int K = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [SUM_BITS-1:0]   rem_in,
	input  logic [ROOT_BITS-1:0]  root_in,
	input  logic [NORM_BITS-1:0]  y_in,
	input  side_t                 side_in,
	output logic                  valid_out,
	output logic [SUM_BITS-1:0]   rem_out,
	output logic [ROOT_BITS-1:0]  root_out,
	output logic [NORM_BITS-1:0]  y_out,
	output side_t                 side_out
);

	logic [ROOT_BITS:0]  base;
	logic [SUM_BITS:0]   trial;
	logic                take;
	logic                valid_q;
	logic [SUM_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [NORM_BITS-1:0] y_q;
	side_t               side_q;

	// Try to set root bit K: subtract (2*root + 2^K) * 2^K
	always_comb begin
		base  = {root_in, 1'b0} | ((ROOT_BITS + 1)'(1) << K);
		trial = {{(SUM_BITS - ROOT_BITS){1'b0}}, base} << K;
		take  = {1'b0, rem_in} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= take ? SUM_BITS'({1'b0, rem_in} - trial) : rem_in;
			root_q <= take ? (root_in | (ROOT_BITS'(1) << K)) : root_in;
			y_q    <= y_in;
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;
	assign y_out     = y_q;
	assign side_out  = side_q;

endmodule

// File: design/atr_cordic_cell.sv
`timescale 1ns / 1ps
module atr_cordic_cell import atr_pkg::*; #(
	parameter int I = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_in,
	input  logic signed [CX_BITS-1:0]  x_in,
	input  logic signed [CX_BITS-1:0]  y_in,
	input  logic signed [ANG_BITS-1:0] z_in,
	input  side_t                      side_in,
	output logic                       valid_out,
	output logic signed [CX_BITS-1:0]  x_out,
	output logic signed [CX_BITS-1:0]  y_out,
	output logic signed [ANG_BITS-1:0] z_out,
	output side_t                      side_out
);

	localparam logic signed [ANG_BITS-1:0] ANG = step_angle(I);

	logic signed [CX_BITS-1:0] xs, ys;
	logic                      up;
	logic                      valid_q;
	logic signed [CX_BITS-1:0] x_q, y_q;
	logic signed [ANG_BITS-1:0] z_q;
	side_t                     side_q;

	// Rotate toward the x axis by atan(2^-I)
	always_comb begin
		xs = x_in >>> I;
		ys = y_in >>> I;
		up = y_in > 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= up ? x_in + ys : x_in - ys;
			y_q    <= up ? y_in - xs : y_in + xs;
			z_q    <= up ? z_in + ANG : z_in - ANG;
			side_q <= side_in;
		end
	end

	assign valid_out = valid_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;
	assign side_out  = side_q;

endmodule

// File: design/accelerometer_tilt_angle.sv
// Pipeline from input transfer to result: six front stages, 31 square-root cells,
// one CORDIC cell per step, one output register.
// Throughput: one sample set per cycle while in_stall is low; the cell chain advances as a whole.
// Reset clears all valid bits and loads bias 1650 mV and gain 330 mV/g on every axis.
`timescale 1ns / 1ps
module accelerometer_tilt_angle import atr_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	logic [REG_W-1:0] bias_q [3];
	logic [REG_W-1:0] gain_q [3];

	logic en, out_free;

	logic                 sq_valid [ROOT_BITS+1];
	logic [SUM_BITS-1:0]  sq_rem   [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] sq_root  [ROOT_BITS+1];
	logic [NORM_BITS-1:0] sq_y     [ROOT_BITS+1];
	side_t                sq_side  [ROOT_BITS+1];

	logic                       cd_valid [CORDIC_STEPS+1];
	logic signed [CX_BITS-1:0]  cd_x     [CORDIC_STEPS+1];
	logic signed [CX_BITS-1:0]  cd_y     [CORDIC_STEPS+1];
	logic signed [ANG_BITS-1:0] cd_z     [CORDIC_STEPS+1];
	side_t                      cd_side  [CORDIC_STEPS+1];

	logic                  out_valid_q;
	out_t                  out_data_q;
	out_t                  result;
	logic [ANG_BITS-2:0]   zabs;
	logic [ANG_BITS-2:0]   rnd;
	logic [MAGN_W-1:0]     magn;
	logic                  neg;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				bias_q[k] <= REG_W'(1650);
				gain_q[k] <= REG_W'(330);
			end
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BIAS_X: bias_q[0] <= cfg_data;
				REG_BIAS_Y: bias_q[1] <= cfg_data;
				REG_BIAS_Z: bias_q[2] <= cfg_data;
				REG_GAIN_X: gain_q[0] <= cfg_data;
				REG_GAIN_Y: gain_q[1] <= cfg_data;
				REG_GAIN_Z: gain_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the chain unless a held result blocks a valid item at its end
	assign out_free = !out_valid_q || !out_stall;
	assign en       = out_free || !cd_valid[CORDIC_STEPS];
	assign in_stall = !en;

	atr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.bias     (bias_q),
		.gain     (gain_q),
		.valid    (sq_valid[0]),
		.sum      (sq_rem[0]),
		.y_mag    (sq_y[0]),
		.side     (sq_side[0])
	);
	assign sq_root[0] = '0;

	// Square root, one result bit per cell
	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sqrt
		atr_sqrt_cell #(.K(ROOT_BITS - 1 - j)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (sq_valid[j]),
			.rem_in    (sq_rem[j]),
			.root_in   (sq_root[j]),
			.y_in      (sq_y[j]),
			.side_in   (sq_side[j]),
			.valid_out (sq_valid[j+1]),
			.rem_out   (sq_rem[j+1]),
			.root_out  (sq_root[j+1]),
			.y_out     (sq_y[j+1]),
			.side_out  (sq_side[j+1])
		);
	end

	assign cd_valid[0] = sq_valid[ROOT_BITS];
	assign cd_x[0]     = $signed(CX_BITS'(sq_root[ROOT_BITS]));
	assign cd_y[0]     = $signed(CX_BITS'(sq_y[ROOT_BITS]));
	assign cd_z[0]     = '0;
	assign cd_side[0]  = sq_side[ROOT_BITS];

	// CORDIC vectoring, one step per cell
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		atr_cordic_cell #(.I(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (cd_valid[i]),
			.x_in      (cd_x[i]),
			.y_in      (cd_y[i]),
			.z_in      (cd_z[i]),
			.side_in   (cd_side[i]),
			.valid_out (cd_valid[i+1]),
			.x_out     (cd_x[i+1]),
			.y_out     (cd_y[i+1]),
			.z_out     (cd_z[i+1]),
			.side_out  (cd_side[i+1])
		);
	end

	// Round to centidegrees, clamp, apply signs and special cases
	always_comb begin
		zabs = cd_z[CORDIC_STEPS][ANG_BITS-1] ? (ANG_BITS-1)'(-cd_z[CORDIC_STEPS])
			: (ANG_BITS-1)'(cd_z[CORDIC_STEPS]);
		rnd  = (zabs + (ANG_BITS-1)'(32768)) >> 16;
		magn = (rnd > (ANG_BITS-1)'(QUARTER_CENTIDEG)) ? MAGN_W'(QUARTER_CENTIDEG)
			: MAGN_W'(rnd);
		neg  = cd_z[CORDIC_STEPS][ANG_BITS-1] ^ cd_side[CORDIC_STEPS].neg_y;
		result.undefined_flag = 1'b0;
		if (cd_side[CORDIC_STEPS].all_zero) begin
			result.tilt_centideg  = '0;
			result.undefined_flag = 1'b1;
		end else if (cd_side[CORDIC_STEPS].xz_zero) begin
			result.tilt_centideg = cd_side[CORDIC_STEPS].neg_y
				? -TILT_W'(QUARTER_CENTIDEG) : TILT_W'(QUARTER_CENTIDEG);
		end else begin
			result.tilt_centideg = neg ? -TILT_W'(magn) : TILT_W'(magn);
		end
	end

	// Hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= cd_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && cd_valid[CORDIC_STEPS]) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: design/atr_checker.sv
`timescale 1ns / 1ps
`include "accelerometer_tilt_angle_macros.svh"
module atr_checker import atr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// A stalled result stays and holds its value
	`ATA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ATA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))

	// Undefined tilt reads as zero angle
	`ATA_ASSERT_NOW(a_flag_zero, clk, arst_n, out_valid && out_data.undefined_flag, out_data.tilt_centideg == '0)

	// Angle stays within a quarter turn
	`ATA_ASSERT_NOW(a_range, clk, arst_n, out_valid, (out_data.tilt_centideg <= 15'sd9000) && (out_data.tilt_centideg >= -15'sd9000))

endmodule

bind accelerometer_tilt_angle atr_checker u_atr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: tb/tb_accelerometer_tilt_angle.sv
`timescale 1ns / 1ps
module tb_accelerometer_tilt_angle;
	import atr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_data = '0;

	// Shadow registers, stimulus and expected angles
	logic [REG_W-1:0] bias_mv [3];
	logic [REG_W-1:0] gain_mv [3];
	in_t sample_q[$];
	out_t angle_q[$];
	bit gaps_on = 1'b1;
	int errors = 0;
	int cycles = 0;

	accelerometer_tilt_angle dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CORDIC step angle in units of 2^-16 centidegree
	function automatic longint arc_step(int i);
		longint lut [12] = '{294912000, 174096719, 91987925, 46694507, 23437865,
			11730358, 5866610, 2933484, 1466764, 733385, 366693, 183346};
		if (i < 12)
			return lut[i];
		return longint'((64'd375493621 + (64'd1 << (i - 1))) >> i);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic out_t tilt_of(in_t s);
		longint diff [3];
		longint unsigned mag [3], g [3], top, r, a;
		logic [ADC_BITS-1:0] cnt [3];
		longint cx, cy, cz, xs, ys, res;
		int sh;
		out_t o;
		cnt = '{s.sample_x, s.sample_y, s.sample_z};
		o = '0;
		for (int k = 0; k < 3; k++) begin
			diff[k] = longint'(cnt[k]) * 3600 - (longint'(bias_mv[k]) <<< ADC_BITS);
			g[k] = (gain_mv[k] == 0) ? 1 : gain_mv[k];
			mag[k] = (diff[k] < 0) ? -diff[k] : diff[k];
		end
		// all axes at zero g: angle undefined
		if (diff[0] == 0 && diff[1] == 0 && diff[2] == 0) begin
			o.undefined_flag = 1'b1;
			return o;
		end
		// vertical y axis
		if (diff[0] == 0 && diff[2] == 0) begin
			o.tilt_centideg = (diff[1] < 0) ? -TILT_W'(9000) : TILT_W'(9000);
			return o;
		end
		// cross-scale by gains, then normalize below 2^30
		mag[0] *= g[1] * g[2];
		mag[1] *= g[0] * g[2];
		mag[2] *= g[0] * g[1];
		top = mag[0];
		if (mag[1] > top) top = mag[1];
		if (mag[2] > top) top = mag[2];
		sh = 0;
		while ((top >> sh) >= 64'd1073741824)
			sh++;
		for (int k = 0; k < 3; k++)
			mag[k] >>= sh;
		r = int_sqrt(mag[0] * mag[0] + mag[2] * mag[2]);
		// vector (r, y) onto the x axis
		cx = longint'(r);
		cy = longint'(mag[1]);
		cz = 0;
		for (int i = 0; i < 16; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy > 0) begin
				cx += ys;
				cy -= xs;
				cz += arc_step(i);
			end else begin
				cx -= ys;
				cy += xs;
				cz -= arc_step(i);
			end
		end
		a = (cz < 0) ? -cz : cz;
		a = (a + 32768) >> 16;
		if (a > 9000)
			a = 9000;
		res = (cz < 0) ? -longint'(a) : longint'(a);
		if (diff[1] < 0)
			res = -res;
		o.tilt_centideg = res[TILT_W-1:0];
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Driver: present queued sample sets, predict on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				angle_q.push_back(tilt_of(in_data));
			if (!in_valid || !in_stall) begin
				if (sample_q.size() > 0 && !(gaps_on && $urandom_range(99) < 15)) begin
					in_valid <= 1'b1;
					in_data <= sample_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each result transfer
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (angle_q.size() == 0) begin
					report("unexpected result", out_data.tilt_centideg, 0);
				end else begin
					want = angle_q.pop_front();
					if (out_data.tilt_centideg !== want.tilt_centideg)
						report("tilt_centideg", out_data.tilt_centideg, want.tilt_centideg);
					if (out_data.undefined_flag !== want.undefined_flag)
						report("undefined_flag", out_data.undefined_flag, want.undefined_flag);
				end
			end
			out_stall <= gaps_on && ($urandom_range(99) < 15);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < REG_GAIN_X)
			bias_mv[idx] = val;
		else
			gain_mv[idx - REG_GAIN_X] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_axes(int bx, int by, int bz, int gx, int gy, int gz);
		write_reg(REG_BIAS_X, bx);
		write_reg(REG_BIAS_Y, by);
		write_reg(REG_BIAS_Z, bz);
		write_reg(REG_GAIN_X, gx);
		write_reg(REG_GAIN_Y, gy);
		write_reg(REG_GAIN_Z, gz);
	endtask

	// Random count, often the one that reads exactly zero g when one exists
	function automatic logic [ADC_BITS-1:0] pick_count(int axis);
		if (bias_mv[axis] % 225 == 0 && bias_mv[axis] <= 3375 && $urandom_range(99) < 30)
			return bias_mv[axis] * 256 / 225;
		return $urandom_range(4095);
	endfunction

	task automatic queue_random(int n);
		in_t s;
		for (int i = 0; i < n; i++) begin
			s.sample_x = pick_count(0);
			s.sample_y = pick_count(1);
			s.sample_z = pick_count(2);
			sample_q.push_back(s);
		end
	endtask

	task automatic queue_set(int x, int y, int z);
		sample_q.push_back('{x, y, z});
	endtask

	// Wait for every transfer and result, then let the pipeline settle
	task automatic drain;
		while (sample_q.size() > 0 || in_valid || angle_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		bias_mv = '{1650, 1650, 1650};
		gain_mv = '{330, 330, 330};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings
		queue_set(0, 0, 0);
		queue_set(4095, 4095, 4095);
		queue_random(200);
		drain();

		// zero g reachable at count 1024: special cases and extremes
		set_axes(900, 900, 900, 330, 330, 330);
		queue_set(1024, 1024, 1024);
		queue_set(1024, 4095, 1024);
		queue_set(1024, 0, 1024);
		queue_set(1024, 1025, 1024);
		queue_set(1024, 1023, 1024);
		queue_set(4095, 1024, 1024);
		queue_set(1024, 1024, 0);
		queue_set(0, 4095, 0);
		queue_set(4095, 0, 4095);
		queue_set(0, 0, 0);
		queue_set(4095, 4095, 4095);
		queue_set(1025, 4095, 1024);
		queue_set(1024, 4095, 1023);
		queue_random(200);
		drain();

		// low extremes, no gaps for a long stretch
		gaps_on = 1'b0;
		set_axes(0, 0, 0, 1, 1, 1);
		queue_random(250);
		drain();
		gaps_on = 1'b1;

		// high extremes
		set_axes(3600, 3600, 3600, 3600, 3600, 3600);
		queue_random(200);
		drain();

		// bias above full scale, zero gain taken as one
		set_axes(4095, 4095, 4095, 0, 0, 0);
		queue_random(150);
		drain();

		// mixed axes
		set_axes(225, 1800, 3375, 1, 4095, 0);
		queue_random(250);
		drain();

		// random settings
		for (int p = 0; p < 3; p++) begin
			set_axes($urandom_range(16) * 225, $urandom_range(3600), $urandom_range(16) * 225,
				$urandom_range(1, 3600), $urandom_range(1, 3600), $urandom_range(1, 3600));
			queue_random(90);
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/atr_pkg.sv
design/atr_front.sv
design/atr_sqrt_cell.sv
design/atr_cordic_cell.sv
design/accelerometer_tilt_angle.sv
design/atr_checker.sv
tb/tb_accelerometer_tilt_angle.sv
